FILE: hw/rtl/detvg_pkg.sv
// Package for the differential-evolution trial vector generator.
// Holds command, status and register codes, field widths and the beat structs.
// No dependencies.
package detvg_pkg;

    // Field widths and fixed-point format.
    localparam int VALUE_W    = 32;
    localparam int SCALE_W    = 15;
    localparam int PROB_W     = 16;
    localparam int POP_USE_W  = 6;
    localparam int VEC_USE_W  = 5;
    localparam int ROW_W      = 5;
    localparam int DIM_W      = 4;
    localparam int SCALE_FRAC = 14;
    localparam int REG_ADDR_W = 4;

    // Register reset values.
    localparam logic [SCALE_W-1:0]   DIFF_SCALE_RST = 15'd11469;
    localparam logic [PROB_W-1:0]    CROSS_PROB_RST = 16'd32768;
    localparam logic [POP_USE_W-1:0] POP_USE_RST    = 6'd32;
    localparam logic [VEC_USE_W-1:0] VEC_USE_RST    = 5'd16;

    typedef enum logic [1:0] {
        CMD_LOAD_POP    = 2'd0,
        CMD_LOAD_BEST   = 2'd1,
        CMD_LOAD_BOUNDS = 2'd2,
        CMD_GENERATE    = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_RANGE        = 2'd1,
        ST_NOT_DISTINCT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_DIFF_SCALE        = 2'd0,
        REG_CROSSOVER_PROB    = 2'd1,
        REG_POPULATION_IN_USE = 2'd2,
        REG_VECTOR_IN_USE     = 2'd3
    } t_reg_index;

    // One command beat.
    typedef struct packed {
        t_command                   command;
        logic [ROW_W-1:0]           row_index;
        logic [DIM_W-1:0]           dim_index;
        logic [ROW_W-1:0]           sample_a;
        logic [ROW_W-1:0]           sample_b;
        logic signed [VALUE_W-1:0]  load_value;
        logic signed [VALUE_W-1:0]  upper_value;
        logic [PROB_W-1:0]          random_draw;
    } t_gen_in;

    // One result beat.
    typedef struct packed {
        logic signed [VALUE_W-1:0]  trial_value;
        logic [DIM_W-1:0]           dim_out;
        logic                       crossed;
        t_status                    status;
    } t_gen_out;

endpackage

FILE: hw/rtl/de_trial_vector_generator_core.sv
// Top level of the differential-evolution trial vector generator (best/1 mutation).
// Depends on detvg_pkg for codes, widths and the command and result beat types.
//
// Usage:
//   Commands arrive on i_cmd and are taken at a rising edge with start high and
//   busy low. busy is always low, so one command beat is taken every cycle.
//   Load commands write the population, the best vector or the bounds; a
//   generate command produces one Q16.16 trial element.
//   Every command yields exactly one result beat on o_result, marked by
//   o_valid for one cycle. Each result passes through three registered
//   stages (store read, multiply, shift/add/saturate/clamp), so throughput is
//   one item per cycle.
//   The population memory has one write port and two read ports; a load is
//   written at the edge that takes it, so the next command already sees it.
//   The receiver cannot hold results off; there is no stall path.
//   Reset (i_rst_n low, synchronous) clears the pipeline valid bits and
//   returns the four registers to their defaults. Store contents are left as
//   they are and must be loaded before use. The user must write registers through
//   the APB-style port only while no command is in flight; the core does not check.
module de_trial_vector_generator_core
    import detvg_pkg::*;
#(
    parameter int POP_MAX = 32,
    parameter int DIM_MAX = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  t_gen_in               i_cmd,
    output logic                  o_valid,
    output t_gen_out              o_result
);

    localparam int DEPTH = POP_MAX * DIM_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int DAW   = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

    // Configuration registers.
    logic [SCALE_W-1:0]   r_diff_scale;
    logic [PROB_W-1:0]    r_cross_prob;
    logic [POP_USE_W-1:0] r_pop_use;
    logic [VEC_USE_W-1:0] r_vec_use;
    logic                 cfg_wr;
    t_reg_index           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_scale <= DIFF_SCALE_RST;
            r_cross_prob <= CROSS_PROB_RST;
            r_pop_use    <= POP_USE_RST;
            r_vec_use    <= VEC_USE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DIFF_SCALE:        r_diff_scale <= pwdata[SCALE_W-1:0];
                REG_CROSSOVER_PROB:    r_cross_prob <= pwdata[PROB_W-1:0];
                REG_POPULATION_IN_USE: r_pop_use    <= pwdata[POP_USE_W-1:0];
                REG_VECTOR_IN_USE:     r_vec_use    <= pwdata[VEC_USE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_DIFF_SCALE:        prdata = 32'(r_diff_scale);
            REG_CROSSOVER_PROB:    prdata = 32'(r_cross_prob);
            REG_POPULATION_IN_USE: prdata = 32'(r_pop_use);
            REG_VECTOR_IN_USE:     prdata = 32'(r_vec_use);
            default:               prdata = '0;
        endcase
    end

    // A command beat is taken every cycle.
    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    function automatic logic [AW-1:0] f_addr(input logic [ROW_W-1:0] row,
                                             input logic [DIM_W-1:0] dim);
        f_addr = AW'(AW'(row) * AW'(DIM_MAX) + AW'(dim));
    endfunction

    // Decode: index checks and crossover decision on the incoming beat.
    logic        row_ld_ok, dim_ld_ok;
    logic        row_ok, sa_ok, sb_ok, dim_ok;
    logic        is_gen, gen_ok;
    t_status     n_status;
    logic        n_cross, n_cand;
    logic        wr_pop, wr_best, wr_bounds;
    logic [AW-1:0]  wr_addr, rd_addr_a, rd_addr_b;
    logic [DAW-1:0] dim_sel;

    always_comb begin
        row_ld_ok = 32'(i_cmd.row_index) < POP_MAX;
        dim_ld_ok = 32'(i_cmd.dim_index) < DIM_MAX;
        row_ok    = (32'(i_cmd.row_index) < POP_MAX)
                  && (POP_USE_W'(i_cmd.row_index) < r_pop_use);
        sa_ok     = (32'(i_cmd.sample_a) < POP_MAX)
                  && (POP_USE_W'(i_cmd.sample_a) < r_pop_use);
        sb_ok     = (32'(i_cmd.sample_b) < POP_MAX)
                  && (POP_USE_W'(i_cmd.sample_b) < r_pop_use);
        dim_ok    = (32'(i_cmd.dim_index) < DIM_MAX)
                  && (VEC_USE_W'(i_cmd.dim_index) < r_vec_use);
        is_gen    = 1'b0;
        n_status  = ST_OK;
        case (i_cmd.command)
            CMD_LOAD_POP: begin
                if (!(row_ld_ok && dim_ld_ok)) n_status = ST_RANGE;
            end
            CMD_LOAD_BEST, CMD_LOAD_BOUNDS: begin
                if (!dim_ld_ok) n_status = ST_RANGE;
            end
            CMD_GENERATE: begin
                is_gen = 1'b1;
                if (!(row_ok && sa_ok && sb_ok && dim_ok)) begin
                    n_status = ST_RANGE;
                end else if (i_cmd.row_index == i_cmd.sample_a
                          || i_cmd.row_index == i_cmd.sample_b
                          || i_cmd.sample_a == i_cmd.sample_b) begin
                    n_status = ST_NOT_DISTINCT;
                end
            end
            default: n_status = ST_RANGE;
        endcase
        gen_ok    = is_gen && (n_status == ST_OK);
        n_cross   = gen_ok && (i_cmd.random_draw < r_cross_prob);
        n_cand    = gen_ok && !n_cross;
        wr_pop    = accept && (i_cmd.command == CMD_LOAD_POP) && row_ld_ok && dim_ld_ok;
        wr_best   = accept && (i_cmd.command == CMD_LOAD_BEST) && dim_ld_ok;
        wr_bounds = accept && (i_cmd.command == CMD_LOAD_BOUNDS) && dim_ld_ok;
        wr_addr   = f_addr(i_cmd.row_index, i_cmd.dim_index);
        rd_addr_a = f_addr(n_cross ? i_cmd.sample_a : i_cmd.row_index, i_cmd.dim_index);
        rd_addr_b = f_addr(i_cmd.sample_b, i_cmd.dim_index);
        dim_sel   = DAW'(i_cmd.dim_index);
    end

    // Population memory: one write port, two registered read ports.
    // Port A reads sample_a when crossing, else the candidate's own element.
    logic signed [VALUE_W-1:0] r_pop_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_a, r_rd_b;

    always_ff @(posedge i_clk) begin
        if (wr_pop) r_pop_mem[wr_addr] <= i_cmd.load_value;
        r_rd_a <= r_pop_mem[rd_addr_a];
        r_rd_b <= r_pop_mem[rd_addr_b];
    end

    // Best vector and bounds, one registered read each.
    logic signed [VALUE_W-1:0] r_best_mem [DIM_MAX];
    logic signed [VALUE_W-1:0] r_lo_mem [DIM_MAX];
    logic signed [VALUE_W-1:0] r_hi_mem [DIM_MAX];
    logic signed [VALUE_W-1:0] r_rd_best, r_rd_lo, r_rd_hi;

    always_ff @(posedge i_clk) begin
        if (wr_best) r_best_mem[dim_sel] <= i_cmd.load_value;
        if (wr_bounds) begin
            r_lo_mem[dim_sel] <= i_cmd.load_value;
            r_hi_mem[dim_sel] <= i_cmd.upper_value;
        end
        r_rd_best <= r_best_mem[dim_sel];
        r_rd_lo   <= r_lo_mem[dim_sel];
        r_rd_hi   <= r_hi_mem[dim_sel];
    end

    // Stage 1 control.
    logic             r_s1_valid, r_s1_cross, r_s1_cand;
    logic [DIM_W-1:0] r_s1_dim;
    t_status          r_s1_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_cross  <= n_cross;
        r_s1_cand   <= n_cand;
        r_s1_dim    <= i_cmd.dim_index;
        r_s1_status <= n_status;
    end

    // Stage 2: difference times scale.
    logic signed [VALUE_W:0]   n_diff;
    logic signed [48:0]        n_prod;
    logic signed [48:0]        r_s2_prod;
    logic signed [VALUE_W-1:0] r_s2_best, r_s2_lo, r_s2_hi, r_s2_cand;
    logic                      r_s2_valid, r_s2_cross, r_s2_cand_sel;
    logic [DIM_W-1:0]          r_s2_dim;
    t_status                   r_s2_status;

    assign n_diff = (VALUE_W+1)'(r_rd_a) - (VALUE_W+1)'(r_rd_b);
    assign n_prod = 49'(n_diff) * 49'($signed({1'b0, r_diff_scale}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_prod     <= n_prod;
        r_s2_best     <= r_rd_best;
        r_s2_lo       <= r_rd_lo;
        r_s2_hi       <= r_rd_hi;
        r_s2_cand     <= r_rd_a;
        r_s2_cross    <= r_s1_cross;
        r_s2_cand_sel <= r_s1_cand;
        r_s2_dim      <= r_s1_dim;
        r_s2_status   <= r_s1_status;
    end

    // Stage 3: floor shift, add best, saturate, clamp to the bounds, then pick the crossed, candidate or zero value.
    logic signed [34:0]        n_scaled;
    logic signed [35:0]        n_sum;
    logic signed [VALUE_W-1:0] n_sat, n_clamp, n_trial;

    always_comb begin
        n_scaled = r_s2_prod[48:SCALE_FRAC];
        n_sum    = 36'(r_s2_best) + 36'(n_scaled);
        if (n_sum[35:31] != {5{n_sum[35]}}) begin
            n_sat = n_sum[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            n_sat = n_sum[31:0];
        end
        n_clamp = n_sat;
        if (n_clamp < r_s2_lo) n_clamp = r_s2_lo;
        if (n_clamp > r_s2_hi) n_clamp = r_s2_hi;
        if (r_s2_cross) begin
            n_trial = n_clamp;
        end else if (r_s2_cand_sel) begin
            n_trial = r_s2_cand;
        end else begin
            n_trial = '0;
        end
    end

    // Result register.
    logic     r_out_valid;
    t_gen_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s2_valid;
        end
        r_out.trial_value <= n_trial;
        r_out.dim_out     <= r_s2_dim;
        r_out.crossed     <= r_s2_cross;
        r_out.status      <= r_s2_status;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: hw/rtl/detvg_checker.sv
// Port-level checker for de_trial_vector_generator_core, with its bind.
// Depends on detvg_pkg and on the top level's port names.
module detvg_checker
    import detvg_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_gen_in  i_cmd,
    input logic     o_valid,
    input t_gen_out o_result
);

    // Every command beat yields a result beat.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("command beat without a result beat");

    // No result beat appears without a command beat behind it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result beat without a command beat");

    // Load commands give a zero trial value and no crossover.
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.command != CMD_GENERATE)
        |-> ##3 (o_result.trial_value == 32'sd0 && !o_result.crossed))
        else $error("load command gave a nonzero trial value");

    // A crossed element only comes from a successful generate.
    a_cross_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.crossed) |-> (o_result.status == ST_OK))
        else $error("crossed result with a failing status");

    // The dimension travels with its command.
    a_dim_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 (o_result.dim_out == $past(i_cmd.dim_index, 3)))
        else $error("result dimension does not match the command");

endmodule

bind de_trial_vector_generator_core detvg_checker u_detvg_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for de_trial_vector_generator_core.
// Drives command beats and APB register writes, predicts each trial element and checks it.
// Depends on detvg_pkg and the core RTL only.
module tb;
    import detvg_pkg::*;

    localparam int     POP_MAX      = 32;
    localparam int     DIM_MAX      = 16;
    localparam int     PIPE_LATENCY = 3;
    localparam int     DRAIN_LIMIT  = 64;
    localparam int     RUN_LIMIT    = 5_000_000;
    localparam longint VAL_MAX      = 64'sd2147483647;
    localparam longint VAL_MIN      = -64'sd2147483648;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    t_gen_in               i_cmd;
    logic                  o_valid;
    t_gen_out              o_result;

    // Predictor state: stores and register copies.
    logic signed [VALUE_W-1:0] pop_mem [POP_MAX][DIM_MAX];
    logic signed [VALUE_W-1:0] best_mem [DIM_MAX];
    logic signed [VALUE_W-1:0] lower_mem [DIM_MAX];
    logic signed [VALUE_W-1:0] upper_mem [DIM_MAX];
    logic [SCALE_W-1:0]        cfg_scale   = DIFF_SCALE_RST;
    logic [PROB_W-1:0]         cfg_prob    = CROSS_PROB_RST;
    logic [POP_USE_W-1:0]      cfg_pop_use = POP_USE_RST;
    logic [VEC_USE_W-1:0]      cfg_vec_use = VEC_USE_RST;

    t_gen_out pending_trials [$];

    int gap_pct = 21;
    int errors = 0;
    int n_commands = 0;
    int n_results = 0;
    int n_crossed = 0;
    int n_range = 0;
    int n_repeat = 0;
    int n_settings = 0;

    de_trial_vector_generator_core #(
        .POP_MAX(POP_MAX),
        .DIM_MAX(DIM_MAX)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic int unsigned rows_in_use();
        return (cfg_pop_use < POP_MAX) ? cfg_pop_use : POP_MAX;
    endfunction

    function automatic int unsigned dims_in_use();
        return (cfg_vec_use < DIM_MAX) ? cfg_vec_use : DIM_MAX;
    endfunction

    // Computes the trial element of one command and applies its store writes.
    function automatic t_gen_out predict_trial(input t_gen_in c);
        t_gen_out res;
        longint   diff;
        longint   mutated;
        res = '0;
        res.dim_out = c.dim_index;
        res.status = ST_OK;
        case (c.command)
            CMD_LOAD_POP: begin
                if (c.row_index < POP_MAX && c.dim_index < DIM_MAX)
                    pop_mem[c.row_index][c.dim_index] = c.load_value;
                else
                    res.status = ST_RANGE;
            end
            CMD_LOAD_BEST: begin
                if (c.dim_index < DIM_MAX)
                    best_mem[c.dim_index] = c.load_value;
                else
                    res.status = ST_RANGE;
            end
            CMD_LOAD_BOUNDS: begin
                if (c.dim_index < DIM_MAX) begin
                    lower_mem[c.dim_index] = c.load_value;
                    upper_mem[c.dim_index] = c.upper_value;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            CMD_GENERATE: begin
                if (c.row_index >= rows_in_use() || c.sample_a >= rows_in_use() ||
                    c.sample_b >= rows_in_use() || c.dim_index >= dims_in_use()) begin
                    res.status = ST_RANGE;
                end else if (c.row_index == c.sample_a || c.row_index == c.sample_b ||
                             c.sample_a == c.sample_b) begin
                    res.status = ST_NOT_DISTINCT;
                end else if (c.random_draw < cfg_prob) begin
                    // best + scale * (a - b), floor shift, saturate, then clamp low and high.
                    diff = longint'(pop_mem[c.sample_a][c.dim_index]) -
                           longint'(pop_mem[c.sample_b][c.dim_index]);
                    mutated = longint'(best_mem[c.dim_index]) +
                              ((diff * longint'(cfg_scale)) >>> SCALE_FRAC);
                    if (mutated > VAL_MAX)
                        mutated = VAL_MAX;
                    if (mutated < VAL_MIN)
                        mutated = VAL_MIN;
                    if (mutated < longint'(lower_mem[c.dim_index]))
                        mutated = longint'(lower_mem[c.dim_index]);
                    if (mutated > longint'(upper_mem[c.dim_index]))
                        mutated = longint'(upper_mem[c.dim_index]);
                    res.trial_value = mutated[VALUE_W-1:0];
                    res.crossed = 1'b1;
                end else begin
                    res.trial_value = pop_mem[c.row_index][c.dim_index];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_gen_in make_cmd(input t_command op, input int row, input int dim,
                                         input int sa, input int sb, input logic [31:0] lv,
                                         input logic [31:0] uv, input int draw);
        t_gen_in c;
        c.command     = op;
        c.row_index   = ROW_W'(row);
        c.dim_index   = DIM_W'(dim);
        c.sample_a    = ROW_W'(sa);
        c.sample_b    = ROW_W'(sb);
        c.load_value  = lv;
        c.upper_value = uv;
        c.random_draw = PROB_W'(draw);
        return c;
    endfunction

    // Values lean toward the extremes and small magnitudes.
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            3, 4: return int'($urandom_range(0, 2097152)) - 1048576;
            default: return $urandom;
        endcase
    endfunction

    // Wide bounds half the time, else mostly a random ordered pair, sometimes a possibly crossed pair.
    function automatic void random_bounds(output logic signed [31:0] lo,
                                          output logic signed [31:0] hi);
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = rand_value();
        b = rand_value();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: begin
                lo = 32'sh80000000;
                hi = 32'sh7FFFFFFF;
            end
            7: begin
                lo = a;
                hi = b;
            end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
    endfunction

    function automatic t_gen_in random_cmd();
        t_gen_in            c;
        logic [127:0]       raw;
        int unsigned        pick;
        int unsigned        rows;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        raw = {$urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(t_gen_in)-1:0];
        pick = $urandom_range(0, 99);
        rows = rows_in_use();
        if (pick < 8) begin
            c.command = CMD_LOAD_POP;
            c.load_value = rand_value();
        end else if (pick < 12) begin
            c.command = CMD_LOAD_BEST;
            c.load_value = rand_value();
        end else if (pick < 16) begin
            c.command = CMD_LOAD_BOUNDS;
            random_bounds(lo, hi);
            c.load_value = lo;
            c.upper_value = hi;
        end else begin
            c.command = CMD_GENERATE;
            // Most generates are well formed: distinct rows and a dimension in use.
            if (pick >= 26 && rows >= 3 && dims_in_use() >= 1) begin
                c.row_index = ROW_W'($urandom_range(0, rows - 1));
                do c.sample_a = ROW_W'($urandom_range(0, rows - 1));
                while (c.sample_a == c.row_index);
                do c.sample_b = ROW_W'($urandom_range(0, rows - 1));
                while (c.sample_b == c.row_index || c.sample_b == c.sample_a);
                c.dim_index = DIM_W'($urandom_range(0, dims_in_use() - 1));
            end
            case ($urandom_range(0, 5))
                0: c.random_draw = '0;
                1: c.random_draw = '1;
                2: c.random_draw = cfg_prob;
                3: c.random_draw = cfg_prob - 1'b1;
                default: ;
            endcase
        end
        return c;
    endfunction

    // Sends one command beat, with random idle cycles ahead of it.
    task automatic issue_command(input t_gen_in c);
        while ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_trials.push_back(predict_trial(c));
        n_commands++;
    endtask

    // Holds the sender off until every pending result has come, then lets the pipe settle.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_trials.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_trials.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_trials.size()));
            pending_trials.delete();
        end
        repeat (PIPE_LATENCY + 1) @(posedge i_clk);
    endtask

    // One APB write followed by a read back of the same register.
    task automatic set_register(input t_reg_index idx, input logic [31:0] value);
        logic [31:0] readback;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_DIFF_SCALE:        cfg_scale   = value[SCALE_W-1:0];
            REG_CROSSOVER_PROB:    cfg_prob    = value[PROB_W-1:0];
            REG_POPULATION_IN_USE: cfg_pop_use = value[POP_USE_W-1:0];
            REG_VECTOR_IN_USE:     cfg_vec_use = value[VEC_USE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        readback = prdata;
        if (readback !== value)
            report_mismatch($sformatf("register %s read %h, wrote %h", idx.name(), readback,
                                      value));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Applies one register setting while idle, then sends random commands under it.
    task automatic run_phase(input logic [SCALE_W-1:0] scale, input logic [PROB_W-1:0] prob,
                             input logic [POP_USE_W-1:0] pop_use,
                             input logic [VEC_USE_W-1:0] vec_use, input int count);
        wait_for_results();
        set_register(REG_DIFF_SCALE, 32'(scale));
        set_register(REG_CROSSOVER_PROB, 32'(prob));
        set_register(REG_POPULATION_IN_USE, 32'(pop_use));
        set_register(REG_VECTOR_IN_USE, 32'(vec_use));
        n_settings++;
        repeat (count) issue_command(random_cmd());
    endtask

    // Result checker: each beat against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_gen_out want;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                report_mismatch("result strobe is unknown");
            end else if (o_valid) begin
                n_results++;
                if (pending_trials.size() == 0) begin
                    report_mismatch("result beat with nothing pending");
                end else begin
                    want = pending_trials.pop_front();
                    if (o_result.trial_value !== want.trial_value)
                        report_mismatch($sformatf("trial_value %h, predicted %h",
                                                  o_result.trial_value, want.trial_value));
                    if (o_result.dim_out !== want.dim_out)
                        report_mismatch($sformatf("dim_out %0d, predicted %0d",
                                                  o_result.dim_out, want.dim_out));
                    if (o_result.crossed !== want.crossed)
                        report_mismatch($sformatf("crossed %b, predicted %b",
                                                  o_result.crossed, want.crossed));
                    if (o_result.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  o_result.status, want.status));
                    n_crossed += want.crossed;
                    n_range += (want.status == ST_RANGE);
                    n_repeat += (want.status == ST_NOT_DISTINCT);
                end
            end
        end
    end

    // Writes every store entry so no generate ever reads an unwritten word.
    task automatic test_store_fill();
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        for (int r = 0; r < POP_MAX; r++)
            for (int d = 0; d < DIM_MAX; d++)
                issue_command(make_cmd(CMD_LOAD_POP, r, d, 0, 0, rand_value(), 0, 0));
        for (int d = 0; d < DIM_MAX; d++) begin
            random_bounds(lo, hi);
            issue_command(make_cmd(CMD_LOAD_BEST, 0, d, 0, 0, rand_value(), 0, 0));
            issue_command(make_cmd(CMD_LOAD_BOUNDS, 0, d, 0, 0, lo, hi, 0));
        end
    endtask

    // Saturation both ways, floor rounding, draw boundaries, clamping and repeated rows.
    task automatic test_corner_cases();
        issue_command(make_cmd(CMD_LOAD_POP, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0));
        issue_command(make_cmd(CMD_LOAD_POP, 1, 0, 0, 0, 32'h80000000, 0, 0));
        issue_command(make_cmd(CMD_LOAD_BEST, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0));
        issue_command(make_cmd(CMD_LOAD_BOUNDS, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0));
        issue_command(make_cmd(CMD_GENERATE, 2, 0, 0, 1, 0, 0, 0));
        issue_command(make_cmd(CMD_LOAD_BEST, 0, 0, 0, 0, 32'h80000000, 0, 0));
        issue_command(make_cmd(CMD_GENERATE, 2, 0, 1, 0, 0, 0, 0));
        // A difference of minus one must round down, not toward zero.
        issue_command(make_cmd(CMD_LOAD_POP, 3, 1, 0, 0, 0, 0, 0));
        issue_command(make_cmd(CMD_LOAD_POP, 4, 1, 0, 0, 1, 0, 0));
        issue_command(make_cmd(CMD_LOAD_BEST, 0, 1, 0, 0, 0, 0, 0));
        issue_command(make_cmd(CMD_LOAD_BOUNDS, 0, 1, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0));
        issue_command(make_cmd(CMD_GENERATE, 5, 1, 3, 4, 0, 0, 32767));
        issue_command(make_cmd(CMD_GENERATE, 5, 1, 3, 4, 0, 0, 32768));
        issue_command(make_cmd(CMD_GENERATE, 5, 1, 3, 4, 0, 0, 65535));
        // Clamp to the lower bound, then crossed bounds where the upper one wins.
        issue_command(make_cmd(CMD_LOAD_BOUNDS, 0, 1, 0, 0, 100, 200, 0));
        issue_command(make_cmd(CMD_GENERATE, 5, 1, 4, 3, 0, 0, 0));
        issue_command(make_cmd(CMD_LOAD_BOUNDS, 0, 1, 0, 0, 500, 200, 0));
        issue_command(make_cmd(CMD_GENERATE, 5, 1, 4, 3, 0, 0, 0));
        // Rows that are not pairwise distinct.
        issue_command(make_cmd(CMD_GENERATE, 5, 1, 5, 3, 0, 0, 0));
        issue_command(make_cmd(CMD_GENERATE, 5, 1, 3, 5, 0, 0, 0));
        issue_command(make_cmd(CMD_GENERATE, 6, 1, 3, 3, 0, 0, 0));
        issue_command(make_cmd(CMD_GENERATE, 31, 15, 30, 29, 0, 32'hFFFFFFFF, 0));
    endtask

    // Register extremes, including zero and over-range row and dimension counts.
    task automatic test_register_sweep();
        run_phase(15'd0, 16'hFFFF, 6'd32, 5'd16, 60);
        run_phase(15'h7FFF, 16'd0, 6'd3, 5'd1, 60);
        run_phase(15'h7FFF, 16'hFFFF, 6'd3, 5'd16, 60);
        run_phase(15'd1, 16'd1, 6'd0, 5'd16, 40);
        run_phase(15'd16384, 16'd40000, 6'd63, 5'd31, 60);
        run_phase(15'd5000, 16'd20000, 6'd17, 5'd0, 40);
        repeat (2)
            run_phase(SCALE_W'($urandom), PROB_W'($urandom),
                      POP_USE_W'($urandom_range(3, 32)), VEC_USE_W'($urandom_range(1, 16)), 60);
    endtask

    // Long random runs: heavy sender gaps first, then back to back.
    task automatic test_random_traffic();
        gap_pct = 57;
        run_phase(DIFF_SCALE_RST, CROSS_PROB_RST, POP_USE_RST, VEC_USE_RST, 450);
        gap_pct = 0;
        run_phase(15'd12000, 16'd50000, 6'd32, 5'd16, 450);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        i_cmd = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_store_fill();
        test_corner_cases();
        test_register_sweep();
        test_random_traffic();
        wait_for_results();

        $display("Run covered %0d commands and %0d results over %0d register settings.",
                 n_commands, n_results, n_settings);
        $display("Results: %0d crossed, %0d range errors, %0d repeated rows, %0d mismatches.",
                 n_crossed, n_range, n_repeat, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
